FILE: hw/rtl/efp_pkg.sv
// Shared types, constants and helpers of the escape-time fractal pixel engine.
`default_nettype none

package efp_pkg;

  // Fixed point word: signed, QW bits, fraction position set by FRAC_BITS.
  localparam int QW      = 48;
  localparam int STEP_W  = 47;
  localparam int CNT_W   = 16;
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 3;

  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 36;

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  // Register values after reset.
  localparam logic signed [QW-1:0]     ORIGIN_RE_RST = -48'sd137438953472;
  localparam logic signed [QW-1:0]     ORIGIN_IM_RST = -48'sd137438953472;
  localparam logic [STEP_W-1:0]        STEP_RE_RST   = 47'd458129845;
  localparam logic [STEP_W-1:0]        STEP_IM_RST   = 47'd458129845;
  localparam logic signed [QW-1:0]     JULIA_RE_RST  = -48'sd57385447260;
  localparam logic signed [QW-1:0]     JULIA_IM_RST  = -48'sd15938564014;
  localparam logic [CNT_W-1:0]         MAX_ITER_RST  = 16'd100;

  typedef enum logic [IDX_W-1:0] {
    CFG_ORIGIN_RE    = 3'd0,
    CFG_ORIGIN_IM    = 3'd1,
    CFG_STEP_RE      = 3'd2,
    CFG_STEP_IM      = 3'd3,
    CFG_JULIA_C_RE   = 3'd4,
    CFG_JULIA_C_IM   = 3'd5,
    CFG_MAX_ITER     = 3'd6,
    CFG_FRACTAL_MODE = 3'd7
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_MANDELBROT = 2'd0,
    MODE_JULIA      = 2'd1,
    MODE_SHIP       = 2'd2
  } fractal_mode_e;

  localparam logic [MODE_W-1:0] MODE_RST = MODE_MANDELBROT;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_INIT,
    ST_CHECK,
    ST_MUL,
    ST_ADD,
    ST_SCALE,
    ST_SUM,
    ST_COMMIT,
    ST_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic map_mul;
    logic map_add;
    logic init;
    logic mag;
    logic mul;
    logic add;
    logic scale;
    logic sum;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic iter_left;
    logic esc;
  } ctrl_sts_t;

  // Saturate a value with two guard bits to the QW-bit range.
  function automatic logic signed [QW-1:0] sat_q(input logic signed [QW+1:0] v);
    logic [2:0] top;
    top = v[QW+1:QW-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[QW-1:0];
    end else if (v[QW+1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/escape_time_fractal_pixel.sv
// Top level of the escape-time fractal pixel engine (Mandelbrot, Julia, burning ship).
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   in       | in_valid_i / in_ready_o    | pixel_x_i, pixel_y_i
//   out      | out_valid_o / out_ready_i  | iter_count_o, final_re_o, final_im_o
//   config   | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// One pixel request is worked on at a time; each pass of the iteration loop steps
// through the states CHECK, MUL, ADD, SCALE, SUM and COMMIT, and a pass that finds an
// escape or a stuck point ends the loop before the result is handed off.
// Reset is asynchronous and active low and restores the register defaults.
// A finished result waits in the output register while the next request runs; the
// engine stalls only if a second result is ready before the first has been taken.
`default_nettype none

module escape_time_fractal_pixel #(
  parameter int COORD_BITS = efp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = efp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Configuration write port.
  input  wire logic                       cfg_we_i,
  input  wire logic [efp_pkg::IDX_W-1:0]  cfg_idx_i,
  input  wire logic [efp_pkg::QW-1:0]     cfg_data_i,
  // Pixel requests.
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [COORD_BITS-1:0]      pixel_x_i,
  input  wire logic [COORD_BITS-1:0]      pixel_y_i,
  // Results.
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [efp_pkg::CNT_W-1:0]       iter_count_o,
  output logic signed [efp_pkg::QW-1:0]  final_re_o,
  output logic signed [efp_pkg::QW-1:0]  final_im_o
);
  import efp_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The controller decides the order of operations; the datapath holds every
  // number, including the configuration, and reports only whether iterations
  // remain and whether the point has escaped.
  efp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  efp_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .iter_count_o (iter_count_o),
    .final_re_o   (final_re_o),
    .final_im_o   (final_im_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/efp_qmul.sv
// Multi-cycle fixed point multiplier with floor rounding and saturation.
`default_nettype none

module efp_qmul #(
  parameter int SHIFT = 36
) (
  input  wire logic                             clk_i,
  input  wire logic                             en_mag_i,
  input  wire logic                             en_mul_i,
  input  wire logic                             en_add_i,
  input  wire logic                             en_scale_i,
  input  wire logic signed [efp_pkg::QW-1:0]    a_i,
  input  wire logic signed [efp_pkg::QW-1:0]    b_i,
  output logic signed [efp_pkg::QW-1:0]         res_o
);
  import efp_pkg::*;

  localparam int HW = QW / 2;
  localparam int PW = 2 * QW;

  logic              neg_q;
  logic [QW-1:0]     amag_q, bmag_q;
  logic [QW-1:0]     amag_d, bmag_d;
  logic [QW-1:0]     pp_q [4];
  logic [QW-1:0]     pp_d [4];
  logic [PW-1:0]     prod_q, prod_d;
  logic signed [QW-1:0] res_q, res_d;
  logic [PW-1:0]     shifted;
  logic              dropped;
  logic              ovf_pos, ovf_neg;

  // Stage 1: magnitudes; the most negative value maps to 2^(QW-1).
  always_comb begin
    amag_d = a_i[QW-1] ? (~a_i + QW'(1)) : a_i;
    bmag_d = b_i[QW-1] ? (~b_i + QW'(1)) : b_i;
  end

  // Stage 2: four half-width partial products.
  always_comb begin
    pp_d[0] = QW'(amag_q[HW-1:0])  * QW'(bmag_q[HW-1:0]);
    pp_d[1] = QW'(amag_q[HW-1:0])  * QW'(bmag_q[QW-1:HW]);
    pp_d[2] = QW'(amag_q[QW-1:HW]) * QW'(bmag_q[HW-1:0]);
    pp_d[3] = QW'(amag_q[QW-1:HW]) * QW'(bmag_q[QW-1:HW]);
  end

  // Stage 3: outer products do not overlap, so they concatenate.
  always_comb begin
    prod_d = {pp_q[3], pp_q[0]}
           + (PW'({1'b0, pp_q[1]} + {1'b0, pp_q[2]}) << HW);
  end

  // Stage 4: floor of the signed quotient. For a negative result the
  // negated ceiling is ~shifted plus one unless bits were dropped.
  always_comb begin
    shifted = prod_q >> SHIFT;
    dropped = |(prod_q << (PW - SHIFT));
    ovf_pos = |shifted[PW-1:QW-1];
    ovf_neg = ovf_pos || (&shifted[QW-2:0] && dropped);
    if (neg_q) begin
      res_d = ovf_neg ? Q_MIN : (~shifted[QW-1:0] + QW'(!dropped));
    end else begin
      res_d = ovf_pos ? Q_MAX : shifted[QW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_mag_i) begin
      neg_q  <= a_i[QW-1] ^ b_i[QW-1];
      amag_q <= amag_d;
      bmag_q <= bmag_d;
    end
    if (en_mul_i) begin
      pp_q <= pp_d;
    end
    if (en_add_i) begin
      prod_q <= prod_d;
    end
    if (en_scale_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/efp_datapath.sv
// Datapath: configuration registers, coordinate mapping, iteration and result registers.
`default_nettype none

module efp_datapath #(
  parameter int COORD_BITS = efp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = efp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [efp_pkg::IDX_W-1:0]      cfg_idx_i,
  input  wire logic [efp_pkg::QW-1:0]         cfg_data_i,
  input  wire logic [COORD_BITS-1:0]          pixel_x_i,
  input  wire logic [COORD_BITS-1:0]          pixel_y_i,
  input  wire efp_pkg::ctrl_cmd_t             cmd_i,
  output efp_pkg::ctrl_sts_t                  sts_o,
  output logic [efp_pkg::CNT_W-1:0]           iter_count_o,
  output logic signed [efp_pkg::QW-1:0]       final_re_o,
  output logic signed [efp_pkg::QW-1:0]       final_im_o
);
  import efp_pkg::*;

  localparam int MPW    = COORD_BITS + STEP_W;
  localparam int EscBit = FRAC_BITS + 8;
  localparam logic [MPW-1:0]  ProdCap   = MPW'(1) << QW;

  function automatic logic signed [QW-1:0] qabs(input logic signed [QW-1:0] v);
    if (v == Q_MIN) begin
      return Q_MAX;
    end else if (v[QW-1]) begin
      return -v;
    end else begin
      return v;
    end
  endfunction

  // Configuration registers.
  logic signed [QW-1:0] origin_re_q, origin_im_q, julia_re_q, julia_im_q;
  logic [STEP_W-1:0]    step_re_q, step_im_q;
  logic [CNT_W-1:0]     max_iter_q;
  logic [MODE_W-1:0]    mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_re_q <= ORIGIN_RE_RST;
      origin_im_q <= ORIGIN_IM_RST;
      step_re_q   <= STEP_RE_RST;
      step_im_q   <= STEP_IM_RST;
      julia_re_q  <= JULIA_RE_RST;
      julia_im_q  <= JULIA_IM_RST;
      max_iter_q  <= MAX_ITER_RST;
      mode_q      <= MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_RE:    origin_re_q <= cfg_data_i;
        CFG_ORIGIN_IM:    origin_im_q <= cfg_data_i;
        CFG_STEP_RE:      step_re_q   <= cfg_data_i[STEP_W-1:0];
        CFG_STEP_IM:      step_im_q   <= cfg_data_i[STEP_W-1:0];
        CFG_JULIA_C_RE:   julia_re_q  <= cfg_data_i;
        CFG_JULIA_C_IM:   julia_im_q  <= cfg_data_i;
        CFG_MAX_ITER:     max_iter_q  <= cfg_data_i[CNT_W-1:0];
        CFG_FRACTAL_MODE: mode_q      <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic is_julia, is_ship;
  assign is_julia = (mode_q == MODE_JULIA);
  assign is_ship  = (mode_q == MODE_SHIP);

  // Coordinate mapping: product first, then clamped add and saturation.
  logic [MPW-1:0]        prod_re_q, prod_im_q;
  logic [QW:0]           clamp_re, clamp_im;
  logic signed [QW+1:0]  map_re, map_im;
  logic signed [QW-1:0]  pre_q, pim_q;

  always_comb begin
    clamp_re = (prod_re_q > ProdCap) ? ProdCap[QW:0] : prod_re_q[QW:0];
    clamp_im = (prod_im_q > ProdCap) ? ProdCap[QW:0] : prod_im_q[QW:0];
    map_re   = {{2{origin_re_q[QW-1]}}, origin_re_q} + {1'b0, clamp_re};
    map_im   = {{2{origin_im_q[QW-1]}}, origin_im_q} + {1'b0, clamp_im};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_mul) begin
      prod_re_q <= MPW'(pixel_x_i) * MPW'(step_re_q);
      prod_im_q <= MPW'(pixel_y_i) * MPW'(step_im_q);
    end
    if (cmd_i.map_add) begin
      pre_q <= sat_q(map_re);
      pim_q <= sat_q(map_im);
    end
  end

  // Iteration state.
  logic signed [QW-1:0] zr_q, zi_q, cr_q, ci_q;
  logic [CNT_W-1:0]     count_q;
  logic signed [QW-1:0] rr, ii, rz;
  logic signed [QW-1:0] nr_q, ni_q;
  logic                 esc_q;

  efp_qmul #(.SHIFT(FRAC_BITS)) u_sq_re (
    .clk_i      (clk_i),
    .en_mag_i   (cmd_i.mag),
    .en_mul_i   (cmd_i.mul),
    .en_add_i   (cmd_i.add),
    .en_scale_i (cmd_i.scale),
    .a_i        (zr_q),
    .b_i        (zr_q),
    .res_o      (rr)
  );

  efp_qmul #(.SHIFT(FRAC_BITS)) u_sq_im (
    .clk_i      (clk_i),
    .en_mag_i   (cmd_i.mag),
    .en_mul_i   (cmd_i.mul),
    .en_add_i   (cmd_i.add),
    .en_scale_i (cmd_i.scale),
    .a_i        (zi_q),
    .b_i        (zi_q),
    .res_o      (ii)
  );

  // Cross term 2*re*im: one fewer bit of shift.
  efp_qmul #(.SHIFT(FRAC_BITS - 1)) u_cross (
    .clk_i      (clk_i),
    .en_mag_i   (cmd_i.mag),
    .en_mul_i   (cmd_i.mul),
    .en_add_i   (cmd_i.add),
    .en_scale_i (cmd_i.scale),
    .a_i        (zr_q),
    .b_i        (zi_q),
    .res_o      (rz)
  );

  // Both squares are non-negative, so their sum needs no sign bit.
  logic [QW:0]          sq_sum;
  logic signed [QW+1:0] nr_sum, ni_sum;
  logic signed [QW-1:0] nr_new, ni_new;
  logic                 stuck;

  always_comb begin
    sq_sum = {1'b0, rr} + {1'b0, ii};
    nr_sum = {{2{rr[QW-1]}}, rr} - {{2{ii[QW-1]}}, ii} + {{2{cr_q[QW-1]}}, cr_q};
    ni_sum = {{2{rz[QW-1]}}, rz} + {{2{ci_q[QW-1]}}, ci_q};
    nr_new = is_ship ? qabs(nr_q) : nr_q;
    ni_new = is_ship ? qabs(ni_q) : ni_q;
    stuck  = (nr_new == zr_q) && (ni_new == zi_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      zr_q <= is_ship ? '0 : pre_q;
      zi_q <= is_ship ? '0 : pim_q;
      cr_q <= is_julia ? julia_re_q : pre_q;
      ci_q <= is_julia ? julia_im_q : pim_q;
    end else if (cmd_i.commit && !esc_q && !stuck) begin
      zr_q <= nr_new;
      zi_q <= ni_new;
    end
    if (cmd_i.sum) begin
      nr_q <= sat_q(nr_sum);
      ni_q <= sat_q(ni_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      esc_q   <= 1'b0;
    end else begin
      if (cmd_i.init) begin
        count_q <= '0;
      end else if (cmd_i.commit && !esc_q) begin
        // A point that no longer moves counts as inside.
        count_q <= stuck ? max_iter_q : count_q + CNT_W'(1);
      end
      if (cmd_i.init) begin
        esc_q <= 1'b0;
      end else if (cmd_i.sum) begin
        esc_q <= (sq_sum >> EscBit) != '0;
      end
    end
  end

  assign sts_o.iter_left = (count_q < max_iter_q);
  assign sts_o.esc       = esc_q;

  // Result registers, loaded once per pixel.
  logic [CNT_W-1:0]     iter_count_q;
  logic signed [QW-1:0] final_re_q, final_im_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      iter_count_q <= count_q;
      final_re_q   <= zr_q;
      final_im_q   <= zi_q;
    end
  end

  assign iter_count_o = iter_count_q;
  assign final_re_o   = final_re_q;
  assign final_im_o   = final_im_q;

endmodule

`default_nettype wire

FILE: hw/rtl/efp_ctrl.sv
// Controller state machine that sequences mapping, iteration and result hand-off.
`default_nettype none

module efp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire efp_pkg::ctrl_sts_t   sts_i,
  output efp_pkg::ctrl_cmd_t        cmd_o
);
  import efp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.map_mul = 1'b1;
          state_d       = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd_o.map_add = 1'b1;
        state_d       = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.iter_left) begin
          cmd_o.mag = 1'b1;
          state_d   = ST_MUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = sts_i.esc ? ST_DONE : ST_CHECK;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an unread result");

  a_valid_rises_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result valid without a finished pixel");

  a_mul_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (($past(state_q) == ST_CHECK) && $past(sts_i.iter_left)))
    else $error("iteration started past the limit");

  a_escape_ends_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT && sts_i.esc) |=> (state_q == ST_DONE))
    else $error("escaped point kept iterating");
`endif

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the escape-time fractal pixel engine.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import efp_pkg::*;

  // The fixed point format and the coordinate width follow the package defaults,
  // and the engine below is built with the same defaults.
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CB   = COORD_BITS_DEF;

  typedef logic signed [QW-1:0]  q_t;
  typedef logic signed [127:0]   wide_t;
  typedef logic [CB-1:0]         coord_t;

  // One result of the engine, in the order of its output ports.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    q_t               re;
    q_t               im;
  } pixel_result_t;

  // Mode code 3 has no name in the package; the engine treats it as Mandelbrot.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam q_t    Q_ONE     = q_t'(64'sd1 <<< FRAC);
  localparam wide_t WIDE_MAX  = wide_t'(Q_MAX);
  localparam wide_t WIDE_MIN  = wide_t'(Q_MIN);
  // The pixel offset is clamped to 2^48 before it is added to the origin.
  localparam wide_t OFS_CLAMP = wide_t'(1) <<< 48;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [IDX_W-1:0]         cfg_idx_i;
  logic [QW-1:0]            cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  coord_t                   pixel_x_i;
  coord_t                   pixel_y_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [CNT_W-1:0]         iter_count_o;
  logic signed [QW-1:0]     final_re_o;
  logic signed [QW-1:0]     final_im_o;

  // Our own copy of the engine's registers, kept in step with every write.
  q_t                 origin_re_q = ORIGIN_RE_RST;
  q_t                 origin_im_q = ORIGIN_IM_RST;
  logic [STEP_W-1:0]  step_re_q   = STEP_RE_RST;
  logic [STEP_W-1:0]  step_im_q   = STEP_IM_RST;
  q_t                 julia_re_q  = JULIA_RE_RST;
  q_t                 julia_im_q  = JULIA_IM_RST;
  logic [CNT_W-1:0]   iter_limit_q = MAX_ITER_RST;
  logic [MODE_W-1:0]  mode_q      = MODE_RST;

  // Results predicted for accepted pixel requests, oldest first.
  pixel_result_t pending_results[$];

  int              mismatch_count = 0;
  int              in_gap_pct     = 16;
  int              out_stall_pct  = 54;
  longint unsigned cycle_count    = 0;
  // Grows with every accepted request by the worst case cycles that request may take.
  longint unsigned cycle_budget   = 20000;

  escape_time_fractal_pixel dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .iter_count_o (iter_count_o),
    .final_re_o   (final_re_o),
    .final_im_o   (final_im_o)
  );

  // 4 ns clock, two delays per period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Fixed point arithmetic of the engine, done exactly in 128 bits.
  // ---------------------------------------------------------------------------

  // Clamp an exact value to the 48-bit signed range.
  function automatic q_t fx_sat(input wide_t v);
    if (v > WIDE_MAX) return Q_MAX;
    if (v < WIDE_MIN) return Q_MIN;
    return v[QW-1:0];
  endfunction

  // Exact product, shifted right with rounding toward minus infinity, then clamped.
  // A shift of FRAC-1 gives the doubled cross term 2*re*im.
  function automatic q_t fx_mul(input q_t a, input q_t b, input int sh);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return fx_sat(p >>> sh);
  endfunction

  // Absolute value; the most negative word has no positive twin and clamps.
  function automatic q_t fx_abs(input q_t v);
    if (v == Q_MIN) return Q_MAX;
    return (v < 0) ? -v : v;
  endfunction

  // One axis of the pixel to plane mapping: origin plus pixel times step.
  function automatic q_t pixel_to_coord(input q_t org, input logic [STEP_W-1:0] stp,
                                        input coord_t pix);
    wide_t ofs;
    ofs = wide_t'(pix) * wide_t'(stp);
    if (ofs > OFS_CLAMP) ofs = OFS_CLAMP;
    return fx_sat(wide_t'(org) + ofs);
  endfunction

  // Escape-time iteration for one pixel under the current register copy.
  function automatic pixel_result_t predict_pixel(input coord_t px, input coord_t py);
    q_t            pr, pi, zr, zi, cr, ci, rr, ii, nr, ni;
    int unsigned   count;
    logic          ship;
    logic          done;
    pixel_result_t r;
    pr   = pixel_to_coord(origin_re_q, step_re_q, px);
    pi   = pixel_to_coord(origin_im_q, step_im_q, py);
    ship = (mode_q == MODE_SHIP);
    if (mode_q == MODE_JULIA) begin
      zr = pr;
      zi = pi;
      cr = julia_re_q;
      ci = julia_im_q;
    end else if (ship) begin
      zr = '0;
      zi = '0;
      cr = pr;
      ci = pi;
    end else begin
      // Mandelbrot, and the spare mode code as well.
      zr = pr;
      zi = pi;
      cr = pr;
      ci = pi;
    end
    count = 0;
    done  = 1'b0;
    while (!done && count < iter_limit_q) begin
      rr = fx_mul(zr, zr, FRAC);
      ii = fx_mul(zi, zi, FRAC);
      // Escape when the integer part of |z|^2 reaches 256.
      if (((wide_t'(rr) + wide_t'(ii)) >>> FRAC) >= 256) begin
        done = 1'b1;
      end else begin
        nr = fx_sat(wide_t'(rr) - wide_t'(ii) + wide_t'(cr));
        ni = fx_sat(wide_t'(fx_mul(zr, zi, FRAC - 1)) + wide_t'(ci));
        if (ship) begin
          nr = fx_abs(nr);
          ni = fx_abs(ni);
        end
        if (nr == zr && ni == zi) begin
          // A fixed point of the map never moves again, so the count jumps to the limit.
          count = iter_limit_q;
          done  = 1'b1;
        end else begin
          zr    = nr;
          zi    = ni;
          count = count + 1;
        end
      end
    end
    r.count = count[CNT_W-1:0];
    r.re    = zr;
    r.im    = zi;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random values for the register settings.
  // ---------------------------------------------------------------------------

  function automatic logic [QW-1:0] rand_word();
    return QW'({$urandom, $urandom});
  endfunction

  // A fixed point value between lo and hi thousandths, with random low bits.
  function automatic q_t rand_near(input int lo_milli, input int hi_milli);
    longint m;
    m = longint'(lo_milli) + longint'($urandom_range(hi_milli - lo_milli));
    return q_t'(m * 64'sd68719477 + longint'($urandom_range(68719476)));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge; the engine samples on the rising.
  // ---------------------------------------------------------------------------

  // The receiver stalls at random, at the rate that the current phase sets.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // Register write; only called while the engine has nothing in flight.
  task automatic write_reg(input cfg_idx_e idx, input logic [QW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_ORIGIN_RE:    origin_re_q  = data;
      CFG_ORIGIN_IM:    origin_im_q  = data;
      CFG_STEP_RE:      step_re_q    = data[STEP_W-1:0];
      CFG_STEP_IM:      step_im_q    = data[STEP_W-1:0];
      CFG_JULIA_C_RE:   julia_re_q   = data;
      CFG_JULIA_C_IM:   julia_im_q   = data;
      CFG_MAX_ITER:     iter_limit_q = data[CNT_W-1:0];
      CFG_FRACTAL_MODE: mode_q       = data[MODE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Present one pixel request, wait for the handshake and record its expected result.
  // Valid stays high after the handshake so that back-to-back requests need no toggle.
  task automatic send_pixel(input coord_t px, input coord_t py);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i  <= px;
    pixel_y_i  <= py;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_pixel(px, py));
    cycle_budget += 6 * longint'(iter_limit_q) + 64;
    @(negedge clk_i);
  endtask

  // Stop requesting, wait for every outstanding result, then let the pipeline settle
  // so that a register write cannot land on a pixel still in flight.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking. Every handshake on the result side is compared with the
  // oldest prediction; extra results and wrong fields are both counted as errors.
  // ---------------------------------------------------------------------------

  task automatic flag_result(input string why, input pixel_result_t want,
                             input pixel_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected count %0d re %0d im %0d, got count %0d re %0d im %0d",
               why, want.count, want.re, want.im, got.count, got.re, got.im);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    pixel_result_t want;
    pixel_result_t got;
    if (out_valid_o && out_ready_i) begin
      got = {iter_count_o, final_re_o, final_im_o};
      if (pending_results.size() == 0) begin
        flag_result("result without a request", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.count !== want.count || got.re !== want.re || got.im !== want.im) begin
          flag_result("result mismatch", want, got);
        end
      end
    end
  end

  // Hang detection: the allowance grows with the worst case of each accepted request.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4 * cycle_budget) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // The default view after reset, including the corners of the pixel grid.
  // Pixel (300,300) lands 28 units of the last place above zero on both axes and gets stuck.
  task automatic test_reset_view();
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel('0, '1);
    send_pixel('1, '0);
    send_pixel(10'd300, 10'd300);
    drain_results();
  endtask

  // Every mode code, the unused code 3 included, on the default view.
  task automatic test_fractal_modes();
    logic [MODE_W-1:0] modes [4];
    modes = '{MODE_MANDELBROT, MODE_JULIA, MODE_SHIP, MODE_SPARE};
    write_reg(CFG_JULIA_C_RE, -48'sd27487790694);
    write_reg(CFG_JULIA_C_IM, 48'sd41231686042);
    foreach (modes[m]) begin
      write_reg(CFG_FRACTAL_MODE, QW'(modes[m]));
      send_pixel(10'd150, 10'd300);
      send_pixel(10'd420, 10'd170);
      drain_results();
    end
  endtask

  // Limit of zero, one and the largest limit, with a stuck point and a fast escape.
  task automatic test_iteration_limits();
    write_reg(CFG_FRACTAL_MODE, QW'(MODE_MANDELBROT));
    write_reg(CFG_ORIGIN_RE, '0);
    write_reg(CFG_ORIGIN_IM, '0);
    write_reg(CFG_STEP_RE, '0);
    write_reg(CFG_STEP_IM, '0);
    // No iteration at all: the result carries the starting point.
    write_reg(CFG_MAX_ITER, '0);
    send_pixel(10'd5, 10'd9);
    drain_results();
    write_reg(CFG_ORIGIN_RE, QW'(3 * Q_ONE));
    send_pixel('0, '0);
    drain_results();
    write_reg(CFG_MAX_ITER, QW'(1));
    send_pixel('0, '0);
    drain_results();
    // Largest limit: c = 3 escapes after two steps, c = 0 sticks at once.
    write_reg(CFG_MAX_ITER, QW'(16'hFFFF));
    send_pixel('0, '0);
    drain_results();
    write_reg(CFG_ORIGIN_RE, '0);
    send_pixel(10'd7, 10'd7);
    drain_results();
  endtask

  // Clamping in the mapping, the exact escape boundary and the absolute value
  // of the most negative word in burning ship mode.
  task automatic test_saturation_cases();
    write_reg(CFG_MAX_ITER, QW'(MAX_ITER_RST));
    write_reg(CFG_ORIGIN_RE, Q_MAX);
    write_reg(CFG_STEP_RE, QW'({STEP_W{1'b1}}));
    send_pixel('1, '0);
    drain_results();
    // |z|^2 of exactly 256 escapes; z one unit of the last place below 16 does not escape at once.
    write_reg(CFG_STEP_RE, '0);
    write_reg(CFG_ORIGIN_RE, QW'(16 * Q_ONE));
    send_pixel('0, '0);
    drain_results();
    write_reg(CFG_ORIGIN_RE, QW'(16 * Q_ONE - 1));
    send_pixel('0, '0);
    drain_results();
    write_reg(CFG_FRACTAL_MODE, QW'(MODE_SHIP));
    write_reg(CFG_ORIGIN_RE, Q_MIN);
    write_reg(CFG_ORIGIN_IM, Q_MIN);
    send_pixel('0, '0);
    drain_results();
    // The clamped offset pushes the most negative origin past the top of the range.
    write_reg(CFG_STEP_RE, QW'({STEP_W{1'b1}}));
    send_pixel('1, '0);
    drain_results();
  endtask

  // Program a random view. Most views sit around the sets so that the iteration
  // count varies; the noisy ones put random words, upper bits included, into
  // every register, but keep the limit small so that a request stays short.
  task automatic pick_view(input bit noisy);
    logic [QW-1:0]    w;
    logic [CNT_W-1:0] lim;
    int               pick;
    if (noisy) begin
      write_reg(CFG_ORIGIN_RE, rand_word());
      write_reg(CFG_ORIGIN_IM, rand_word());
      write_reg(CFG_STEP_RE, rand_word());
      write_reg(CFG_STEP_IM, rand_word());
      write_reg(CFG_JULIA_C_RE, rand_word());
      write_reg(CFG_JULIA_C_IM, rand_word());
      w = rand_word();
      w[CNT_W-1:0] = CNT_W'($urandom_range(40));
      write_reg(CFG_MAX_ITER, w);
      write_reg(CFG_FRACTAL_MODE, rand_word());
    end else begin
      write_reg(CFG_ORIGIN_RE, rand_near(-2500, 500));
      write_reg(CFG_ORIGIN_IM, rand_near(-1800, 600));
      write_reg(CFG_STEP_RE, QW'($urandom_range(1 << 18, 1 << 27)));
      write_reg(CFG_STEP_IM, QW'($urandom_range(1 << 18, 1 << 27)));
      write_reg(CFG_JULIA_C_RE, rand_near(-1000, 500));
      write_reg(CFG_JULIA_C_IM, rand_near(-900, 900));
      pick = $urandom_range(15);
      if (pick == 0) begin
        lim = '0;
      end else if (pick < 3) begin
        lim = CNT_W'($urandom_range(100, 250));
      end else begin
        lim = CNT_W'($urandom_range(1, 48));
      end
      write_reg(CFG_MAX_ITER, QW'(lim));
      write_reg(CFG_FRACTAL_MODE, QW'($urandom_range(3)));
    end
  endtask

  // Batches of random pixels, each batch under a fresh view.
  task automatic test_random_views(input int n_items);
    int sent;
    int batch;
    sent = 0;
    while (sent < n_items) begin
      pick_view($urandom_range(5) == 0);
      batch = $urandom_range(12, 36);
      repeat (batch) send_pixel(coord_t'($urandom), coord_t'($urandom));
      sent += batch;
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, the directed tests, then three random phases that
  // change who idles: first the receiver stalls often, then the sender leaves
  // long gaps between requests, and last both sides run at full rate.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    pixel_x_i   = '0;
    pixel_y_i   = '0;
    out_ready_i = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_view();
    test_fractal_modes();
    test_iteration_limits();
    test_saturation_cases();

    test_random_views(230);
    in_gap_pct    = 54;
    out_stall_pct = 16;
    test_random_views(230);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    test_random_views(230);

    // Everything has been answered; give a stray extra result time to show up.
    repeat (24) @(negedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
